// ===== sv/gcd_pkg.sv =====
// Shared types, constants and the CORDIC arctangent table for the distance/bearing block.
`timescale 1ns / 1ps
`default_nettype none
package gcd_pkg;

   typedef struct packed {
      logic signed [31:0] start_latitude;
      logic signed [31:0] start_longitude;
      logic signed [31:0] end_latitude;
      logic signed [31:0] end_longitude;
   } gcd_req_type;

   typedef struct packed {
      logic [24:0] distance_m;
      logic [31:0] bearing;
   } gcd_rsp_type;

   localparam int TABLE_LEN = 48;
   localparam int SC_W      = 34;   // sin/cos datapath, Q30 with headroom
   localparam int AT_W      = 36;   // atan2 vector datapath
   localparam int AT_ZW     = 34;   // atan2 angle accumulator
   localparam int SQ_W      = 62;   // integer root radicand/remainder
   localparam int SQ_STEPS  = 31;   // root digits for a radicand up to 2^60
   localparam int SQ_RW     = 31;   // root width

   localparam longint QUARTER_TURN = 64'sd1073741824;
   localparam longint HALF_TURN    = 64'sd2147483648;
   localparam longint GAIN_Q30     = 64'sd652032874;
   localparam longint ONE_Q60      = 64'sd1152921504606846976;
   localparam logic [32:0] RPI_Q8  = 33'd5123862220;
   localparam logic [24:0] MAX_DIST = 25'd20015087;

   function automatic logic [31:0] atan_entry(input int unsigned idx);
      logic [31:0] v;
      unique case (idx)
         0:  v = 32'h20000000;
         1:  v = 32'h12E4051E;
         2:  v = 32'h09FB385B;
         3:  v = 32'h051111D4;
         4:  v = 32'h028B0D43;
         5:  v = 32'h0145D7E1;
         6:  v = 32'h00A2F61E;
         7:  v = 32'h00517C55;
         8:  v = 32'h0028BE53;
         9:  v = 32'h00145F2F;
         10: v = 32'h000A2F98;
         11: v = 32'h000517CC;
         12: v = 32'h00028BE6;
         13: v = 32'h000145F3;
         14: v = 32'h0000A2F9;
         15: v = 32'h0000517D;
         16: v = 32'h000028BE;
         17: v = 32'h0000145F;
         18: v = 32'h00000A30;
         19: v = 32'h00000518;
         20: v = 32'h0000028C;
         21: v = 32'h00000146;
         22: v = 32'h000000A3;
         23: v = 32'h00000051;
         24: v = 32'h00000029;
         25: v = 32'h00000014;
         26: v = 32'h0000000A;
         27: v = 32'h00000005;
         28: v = 32'h00000003;
         29: v = 32'h00000001;
         30: v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== sv/gcd_sincos.sv =====
// Pipelined rotation-mode CORDIC: sine and cosine of a binary angle, Q30.
`timescale 1ns / 1ps
`default_nettype none
module gcd_sincos #(
   parameter int STEPS = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   input  logic [31:0]                  in_angle,
   output logic                         out_valid,
   output logic signed [gcd_pkg::SC_W-1:0] out_sin,
   output logic signed [gcd_pkg::SC_W-1:0] out_cos
);
   import gcd_pkg::*;

   logic signed [SC_W-1:0] x_ff [0:STEPS];
   logic signed [SC_W-1:0] y_ff [0:STEPS];
   logic signed [SC_W-1:0] z_ff [0:STEPS];
   logic                   flip_ff [0:STEPS];
   logic                   vld_ff [0:STEPS];
   logic signed [SC_W-1:0] sin_ff, cos_ff;
   logic                   out_vld_ff;

   logic signed [SC_W-1:0] ext_z, fold_z_in;
   logic                   fold_flip_in;

   assign ext_z = $signed({{(SC_W-32){in_angle[31]}}, in_angle});

   // fold into +-90 degrees, negate at the end
   always_comb begin
      fold_z_in    = ext_z;
      fold_flip_in = 1'b0;
      if (ext_z > SC_W'(QUARTER_TURN)) begin
         fold_z_in    = ext_z - SC_W'(HALF_TURN);
         fold_flip_in = 1'b1;
      end else if (ext_z < -SC_W'(QUARTER_TURN)) begin
         fold_z_in    = ext_z + SC_W'(HALF_TURN);
         fold_flip_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= SC_W'(GAIN_Q30);
      y_ff[0]    <= '0;
      z_ff[0]    <= fold_z_in;
      flip_ff[0] <= fold_flip_in;
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [SC_W-1:0] ANG = $signed({{(SC_W-32){1'b0}}, atan_entry(i)});
      always_ff @(posedge clock) begin
         if (!z_ff[i][SC_W-1]) begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - ANG;
         end else begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + ANG;
         end
         flip_ff[i+1] <= flip_ff[i];
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      sin_ff <= flip_ff[STEPS] ? -y_ff[STEPS] : y_ff[STEPS];
      cos_ff <= flip_ff[STEPS] ? -x_ff[STEPS] : x_ff[STEPS];
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else begin
         out_vld_ff <= vld_ff[STEPS];
      end
   end

   assign out_sin   = sin_ff;
   assign out_cos   = cos_ff;
   assign out_valid = out_vld_ff;

endmodule
`default_nettype wire

// ===== sv/gcd_isqrt.sv =====
// Pipelined floor integer square root, one root digit per stage.
`timescale 1ns / 1ps
`default_nettype none
module gcd_isqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [gcd_pkg::SQ_W-1:0]      in_value,
   output logic                          out_valid,
   output logic [gcd_pkg::SQ_RW-1:0]     out_root
);
   import gcd_pkg::*;

   logic [SQ_W-1:0] v_ff [1:SQ_STEPS];
   logic [SQ_W-1:0] r_ff [1:SQ_STEPS];
   logic            vld_ff [1:SQ_STEPS];

   for (genvar j = 0; j < SQ_STEPS; j++) begin : g_digit
      localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - j));
      logic [SQ_W-1:0] src_v, src_r, trial;
      logic            src_vld;
      if (j == 0) begin : g_first
         assign src_v   = in_value;
         assign src_r   = '0;
         assign src_vld = in_valid;
      end else begin : g_next
         assign src_v   = v_ff[j];
         assign src_r   = r_ff[j];
         assign src_vld = vld_ff[j];
      end
      assign trial = src_r + BIT;
      always_ff @(posedge clock) begin
         if (src_v >= trial) begin
            v_ff[j+1] <= src_v - trial;
            r_ff[j+1] <= (src_r >> 1) + BIT;
         end else begin
            v_ff[j+1] <= src_v;
            r_ff[j+1] <= src_r >> 1;
         end
         if (reset) begin
            vld_ff[j+1] <= 1'b0;
         end else begin
            vld_ff[j+1] <= src_vld;
         end
      end
   end

   assign out_root  = r_ff[SQ_STEPS][SQ_RW-1:0];
   assign out_valid = vld_ff[SQ_STEPS];

endmodule
`default_nettype wire

// ===== sv/gcd_atan2.sv =====
// Pipelined vectoring-mode CORDIC: atan2(y, x) in binary angle units.
`timescale 1ns / 1ps
`default_nettype none
module gcd_atan2 #(
   parameter int STEPS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic signed [gcd_pkg::AT_W-1:0] in_x,
   input  logic signed [gcd_pkg::AT_W-1:0] in_y,
   output logic                           out_valid,
   output logic signed [gcd_pkg::AT_ZW-1:0] out_z
);
   import gcd_pkg::*;

   logic signed [AT_W-1:0]  x_ff [0:STEPS];
   logic signed [AT_W-1:0]  y_ff [0:STEPS];
   logic signed [AT_ZW-1:0] z_ff [0:STEPS];
   logic                    vld_ff [0:STEPS];

   // left half plane: rotate by half a turn first
   always_ff @(posedge clock) begin
      if (in_x[AT_W-1]) begin
         x_ff[0] <= -in_x;
         y_ff[0] <= -in_y;
         z_ff[0] <= AT_ZW'(HALF_TURN);
      end else begin
         x_ff[0] <= in_x;
         y_ff[0] <= in_y;
         z_ff[0] <= '0;
      end
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else begin
         vld_ff[0] <= in_valid;
      end
   end

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [AT_ZW-1:0] ANG = $signed({{(AT_ZW-32){1'b0}}, atan_entry(i)});
      always_ff @(posedge clock) begin
         if (!y_ff[i][AT_W-1]) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + ANG;
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - ANG;
         end
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else begin
            vld_ff[i+1] <= vld_ff[i];
         end
      end
   end

   assign out_z     = z_ff[STEPS];
   assign out_valid = vld_ff[STEPS];

endmodule
`default_nettype wire

// ===== sv/gcd_delay.sv =====
// Fixed-length shift line that keeps side data aligned with the pipeline.
`timescale 1ns / 1ps
`default_nettype none
module gcd_delay #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 1
) (
   input  logic             clock,
   input  logic [WIDTH-1:0] in_data,
   output logic [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] tap_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      tap_ff[0] <= in_data;
   end

   for (genvar k = 1; k < DEPTH; k++) begin : g_tap
      always_ff @(posedge clock) begin
         tap_ff[k] <= tap_ff[k-1];
      end
   end

   assign out_data = tap_ff[DEPTH-1];

endmodule
`default_nettype wire

// ===== sv/great_circle_distance_bearing.sv =====
// Top level: haversine great-circle distance and initial bearing pipeline.
//
//  channel  ports                     dir  word
//  request  start, busy, req_data     in   two points, lat/lon binary angles
//  response rsp_valid, rsp_data       out  distance in meters, bearing angle
//
// One point pair enters every clock; busy is tied low since nothing stalls.
// With S = CORDIC_STEPS (limited to 48), the pipeline stages are: input
// register, sin/cos CORDIC (S+2), three multiply stages, 31-stage root,
// atan2 CORDIC (S+1), scale/round (2), output register.
// Synchronous active-high reset clears only the valid bits.
// Each result is shown for one cycle on rsp_valid; the receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none
module great_circle_distance_bearing #(
   parameter int CORDIC_STEPS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  gcd_pkg::gcd_req_type req_data,
   output logic                 rsp_valid,
   output gcd_pkg::gcd_rsp_type rsp_data
);
   import gcd_pkg::*;

   localparam int S   = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
   localparam int LSC = S + 2;

   // ---------------- stage A: angle differences ----------------
   logic signed [32:0] dlat, dlon;
   logic               a_vld_ff, a_co_ff;
   logic [31:0]        a_lat1_ff, a_lat2_ff, a_hdlat_ff, a_hdlon_ff, a_dlon_ff;

   assign busy = 1'b0;
   assign dlat = 33'(req_data.end_latitude) - 33'(req_data.start_latitude);
   assign dlon = 33'(req_data.end_longitude) - 33'(req_data.start_longitude);

   always_ff @(posedge clock) begin
      a_lat1_ff  <= req_data.start_latitude;
      a_lat2_ff  <= req_data.end_latitude;
      a_hdlat_ff <= 32'(dlat >>> 1);
      a_hdlon_ff <= 32'(dlon >>> 1);
      a_dlon_ff  <= dlon[31:0];
      a_co_ff    <= (req_data.start_latitude == req_data.end_latitude) &&
                    (req_data.start_longitude == req_data.end_longitude);
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= start && !busy;
      end
   end

   // ---------------- five sin/cos units ----------------
   logic signed [SC_W-1:0] s1, c1, s2, c2, sdl, sdo, sd, cd;
   logic signed [SC_W-1:0] cdl_unused, cdo_unused;
   logic [4:0]             sc_vld;
   logic                   co_d;

   gcd_sincos #(.STEPS(S)) u_sc_lat1 (.clock, .reset, .in_valid(a_vld_ff),
      .in_angle(a_lat1_ff), .out_valid(sc_vld[0]), .out_sin(s1), .out_cos(c1));
   gcd_sincos #(.STEPS(S)) u_sc_lat2 (.clock, .reset, .in_valid(a_vld_ff),
      .in_angle(a_lat2_ff), .out_valid(sc_vld[1]), .out_sin(s2), .out_cos(c2));
   gcd_sincos #(.STEPS(S)) u_sc_hdlat (.clock, .reset, .in_valid(a_vld_ff),
      .in_angle(a_hdlat_ff), .out_valid(sc_vld[2]), .out_sin(sdl), .out_cos(cdl_unused));
   gcd_sincos #(.STEPS(S)) u_sc_hdlon (.clock, .reset, .in_valid(a_vld_ff),
      .in_angle(a_hdlon_ff), .out_valid(sc_vld[3]), .out_sin(sdo), .out_cos(cdo_unused));
   gcd_sincos #(.STEPS(S)) u_sc_dlon (.clock, .reset, .in_valid(a_vld_ff),
      .in_angle(a_dlon_ff), .out_valid(sc_vld[4]), .out_sin(sd), .out_cos(cd));

   gcd_delay #(.WIDTH(1), .DEPTH(LSC)) u_co_dly (.clock, .in_data(a_co_ff),
      .out_data(co_d));

   // ---------------- M1: first products ----------------
   logic signed [67:0]     p_sdl2, p_c1c2, p_sdo2, p_by, p_c1s2, p_s1c2;
   logic signed [63:0]     m1_sdl2_ff;
   logic signed [SC_W-1:0] m1_c1c2_ff, m1_sdo2_ff, m1_by_ff, m1_c1s2_ff, m1_s1c2_ff;
   logic signed [SC_W-1:0] m1_cd_ff;
   logic                   m1_vld_ff, m1_co_ff;

   assign p_sdl2 = sdl * sdl;
   assign p_c1c2 = c1 * c2;
   assign p_sdo2 = sdo * sdo;
   assign p_by   = sd * c2;
   assign p_c1s2 = c1 * s2;
   assign p_s1c2 = s1 * c2;

   always_ff @(posedge clock) begin
      m1_sdl2_ff <= p_sdl2[63:0];
      m1_c1c2_ff <= p_c1c2[63:30];
      m1_sdo2_ff <= p_sdo2[63:30];
      m1_by_ff   <= p_by[63:30];
      m1_c1s2_ff <= p_c1s2[63:30];
      m1_s1c2_ff <= p_s1c2[63:30];
      m1_cd_ff   <= cd;
      m1_co_ff   <= co_d;
      if (reset) begin
         m1_vld_ff <= 1'b0;
      end else begin
         m1_vld_ff <= &sc_vld;
      end
   end

   // ---------------- M2: second products ----------------
   logic signed [67:0]     p_hav, p_t;
   logic signed [63:0]     m2_sdl2_ff, m2_hav_ff;
   logic signed [SC_W-1:0] m2_t_ff, m2_by_ff, m2_c1s2_ff;
   logic                   m2_vld_ff, m2_co_ff;

   assign p_hav = m1_c1c2_ff * m1_sdo2_ff;
   assign p_t   = m1_s1c2_ff * m1_cd_ff;

   always_ff @(posedge clock) begin
      m2_sdl2_ff <= m1_sdl2_ff;
      m2_hav_ff  <= p_hav[63:0];
      m2_t_ff    <= p_t[63:30];
      m2_by_ff   <= m1_by_ff;
      m2_c1s2_ff <= m1_c1s2_ff;
      m2_co_ff   <= m1_co_ff;
      if (reset) begin
         m2_vld_ff <= 1'b0;
      end else begin
         m2_vld_ff <= m1_vld_ff;
      end
   end

   // ---------------- M3: haversine term and bearing vector ----------------
   logic signed [64:0]     a_sum;
   logic [60:0]            a_clamp;
   logic [60:0]            m3_a_ff;
   logic signed [34:0]     m3_bx_ff;
   logic signed [SC_W-1:0] m3_by_ff;
   logic                   m3_vld_ff, m3_co_ff;

   assign a_sum = 65'(m2_sdl2_ff) + 65'(m2_hav_ff);

   // clamp a into [0, 1] Q60
   always_comb begin
      if (a_sum < 0) begin
         a_clamp = '0;
      end else if (a_sum > 65'(ONE_Q60)) begin
         a_clamp = 61'(ONE_Q60);
      end else begin
         a_clamp = a_sum[60:0];
      end
   end

   always_ff @(posedge clock) begin
      m3_a_ff  <= a_clamp;
      m3_bx_ff <= 35'(m2_c1s2_ff) - 35'(m2_t_ff);
      m3_by_ff <= m2_by_ff;
      m3_co_ff <= m2_co_ff;
      if (reset) begin
         m3_vld_ff <= 1'b0;
      end else begin
         m3_vld_ff <= m2_vld_ff;
      end
   end

   // ---------------- distance path: roots, atan2 ----------------
   logic [SQ_RW-1:0]        root_a, root_b;
   logic [1:0]              sq_vld;
   logic signed [AT_ZW-1:0] theta_z;
   logic                    theta_vld;

   gcd_isqrt u_sqrt_a (.clock, .reset, .in_valid(m3_vld_ff),
      .in_value({1'b0, m3_a_ff}), .out_valid(sq_vld[0]), .out_root(root_a));
   gcd_isqrt u_sqrt_b (.clock, .reset, .in_valid(m3_vld_ff),
      .in_value(SQ_W'(ONE_Q60) - {1'b0, m3_a_ff}), .out_valid(sq_vld[1]),
      .out_root(root_b));

   gcd_atan2 #(.STEPS(S)) u_theta (.clock, .reset, .in_valid(&sq_vld),
      .in_x($signed({{(AT_W-SQ_RW){1'b0}}, root_b})),
      .in_y($signed({{(AT_W-SQ_RW){1'b0}}, root_a})),
      .out_valid(theta_vld), .out_z(theta_z));

   // theta clamped to [0, quarter turn], then scaled by R*pi (Q8)
   logic [30:0] d1_theta_ff;
   logic [63:0] d2_prod_ff;
   logic        d1_vld_ff, d2_vld_ff;
   logic [63:0] dist_round;
   logic [24:0] dist_sat;

   always_ff @(posedge clock) begin
      if (theta_z < 0) begin
         d1_theta_ff <= '0;
      end else if (theta_z > AT_ZW'(QUARTER_TURN)) begin
         d1_theta_ff <= 31'(QUARTER_TURN);
      end else begin
         d1_theta_ff <= theta_z[30:0];
      end
      d2_prod_ff <= 64'(d1_theta_ff) * 64'(RPI_Q8);
      if (reset) begin
         d1_vld_ff <= 1'b0;
         d2_vld_ff <= 1'b0;
      end else begin
         d1_vld_ff <= theta_vld;
         d2_vld_ff <= d1_vld_ff;
      end
   end

   assign dist_round = (d2_prod_ff + (64'd1 << 37)) >> 38;
   assign dist_sat   = (dist_round > 64'(MAX_DIST)) ? MAX_DIST : dist_round[24:0];

   // ---------------- bearing path ----------------
   logic                    zf, zf_d;
   logic signed [AT_ZW-1:0] bear_z;
   logic                    bear_vld;
   logic [31:0]             bear_val, bear_d;

   // undefined direction or coincident points give bearing zero
   assign zf = ((m3_bx_ff == 0) && (m3_by_ff == 0)) || m3_co_ff;

   gcd_atan2 #(.STEPS(S)) u_bear (.clock, .reset, .in_valid(m3_vld_ff),
      .in_x(AT_W'(m3_bx_ff)), .in_y(AT_W'(m3_by_ff)),
      .out_valid(bear_vld), .out_z(bear_z));

   gcd_delay #(.WIDTH(1), .DEPTH(S + 1)) u_zf_dly (.clock, .in_data(zf),
      .out_data(zf_d));

   // idle slots carry zero
   assign bear_val = (zf_d || !bear_vld) ? 32'd0 : bear_z[31:0];

   // wait out the root stages and the scale stages of the distance path
   gcd_delay #(.WIDTH(32), .DEPTH(SQ_STEPS + 2)) u_bear_dly (.clock,
      .in_data(bear_val), .out_data(bear_d));

   // ---------------- output register ----------------
   gcd_rsp_type rsp_ff;
   logic        rsp_vld_ff;

   always_ff @(posedge clock) begin
      rsp_ff.distance_m <= dist_sat;
      rsp_ff.bearing    <= bear_d;
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else begin
         rsp_vld_ff <= d2_vld_ff;
      end
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire
